FILE: src/adex_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adex_pkg
// Shared constants, register codes and arithmetic helpers for the adaptive
// exponential neuron update block.
// ---------------------------------------------------------------------------
package adex_pkg;

    localparam int NEURON_COUNT_DEF = 1024;
    localparam int INDEX_W          = 10;
    localparam int CFG_IDX_W        = 3;
    localparam int DATA_W           = 32;

    localparam logic signed [31:0] RESET_POTENTIAL = -32'sd4626842;
    localparam logic signed [31:0] ADAPT_INCREMENT = 32'sd5276;
    localparam logic signed [31:0] THRESHOLD_PEAK  = -32'sd1966080;
    localparam logic signed [31:0] ADAPT_COUPLING  = 32'sd262144;

    localparam logic signed [47:0] EXP_ARG_MIN = -48'sd1048576;
    localparam logic signed [47:0] EXP_ARG_MAX = 48'sd655360;
    localparam logic signed [31:0] LOG2E_Q16   = 32'sd94548;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEAK_GAIN       = 3'd0,
        REG_REST_POTENTIAL  = 3'd1,
        REG_EXP_GAIN        = 3'd2,
        REG_INV_SLOPE       = 3'd3,
        REG_INPUT_GAIN      = 3'd4,
        REG_THRESHOLD_REST  = 3'd5,
        REG_THRESHOLD_DECAY = 3'd6,
        REG_ADAPT_DECAY     = 3'd7
    } cfg_reg_t;

    // 2^(i/16) in Q16.16
    function automatic logic [17:0] pow2_frac(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92681;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105544;
            5'd12:   v = 18'd110217;
            5'd13:   v = 18'd115097;
            5'd14:   v = 18'd120193;
            5'd15:   v = 18'd125514;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: src/adex_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adex_if
// Handshake channels of the neuron update block: step input, result output
// and register write.
// ---------------------------------------------------------------------------
interface adex_in_if;
    logic                                valid;
    logic                                ready;
    logic [adex_pkg::INDEX_W-1:0]        neuron_index;
    logic signed [adex_pkg::DATA_W-1:0]  input_current;
    modport source (output valid, neuron_index, input_current, input ready);
    modport sink   (input valid, neuron_index, input_current, output ready);
endinterface

interface adex_out_if;
    logic                                valid;
    logic                                ready;
    logic [adex_pkg::INDEX_W-1:0]        neuron_id;
    logic                                spiked;
    logic signed [adex_pkg::DATA_W-1:0]  membrane_now;
    logic [adex_pkg::DATA_W-1:0]         total_spikes;
    modport source (output valid, neuron_id, spiked, membrane_now, total_spikes,
                    input ready);
    modport sink   (input valid, neuron_id, spiked, membrane_now, total_spikes,
                    output ready);
endinterface

interface adex_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [adex_pkg::CFG_IDX_W-1:0]      index;
    logic [adex_pkg::DATA_W-1:0]         data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/adex_neuron_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adex_neuron_update
// One forward-Euler step of an adaptive exponential integrate-and-fire
// neuron per input beat, with per-neuron state held in an on-chip memory.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  in_ch    | sink      | neuron_index, input_current
//  out_ch   | source    | neuron_id, spiked, membrane_now, total_spikes
//  cfg      | sink      | index, data (register write, always ready)
//
//  An item passes from input beat to output beat through a state memory
//  read, seven arithmetic stages, and the output register. One item enters
//  per cycle as long as it names a neuron not already in flight; a repeat of
//  an in-flight neuron waits until that neuron's write-back is done.
//  After reset a clearing pass writes the reset state into all NEURON_COUNT
//  memory rows, one row a cycle, and in_ch stays not ready until the pass
//  is done. A stall on out_ch freezes the whole pipeline in place.
// ---------------------------------------------------------------------------
module adex_neuron_update #(
    parameter int NEURON_COUNT = adex_pkg::NEURON_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    adex_in_if.sink    in_ch,
    adex_out_if.source out_ch,
    adex_cfg_if.sink   cfg
);
    import adex_pkg::*;

    localparam int AW     = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
    localparam int NSTAGE = 8;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] idx;
        logic               inr;
    } tag_t;

    typedef struct packed {
        logic signed [31:0] vm;
        logic signed [31:0] vt;
        logic signed [31:0] x;
    } row_t;

    // ---- configuration registers
    logic [30:0]        leak_gain_reg, exp_gain_reg, inv_slope_reg, input_gain_reg;
    logic signed [31:0] rest_potential_reg, threshold_rest_reg;
    logic [16:0]        threshold_decay_reg, adapt_decay_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_gain_reg       <= '0;
            rest_potential_reg  <= '0;
            exp_gain_reg        <= '0;
            inv_slope_reg       <= 31'd65536;
            input_gain_reg      <= '0;
            threshold_rest_reg  <= '0;
            threshold_decay_reg <= '0;
            adapt_decay_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_LEAK_GAIN:       leak_gain_reg       <= cfg.data[30:0];
                REG_REST_POTENTIAL:  rest_potential_reg  <= cfg.data;
                REG_EXP_GAIN:        exp_gain_reg        <= cfg.data[30:0];
                REG_INV_SLOPE:       inv_slope_reg       <= cfg.data[30:0];
                REG_INPUT_GAIN:      input_gain_reg      <= cfg.data[30:0];
                REG_THRESHOLD_REST:  threshold_rest_reg  <= cfg.data;
                REG_THRESHOLD_DECAY: threshold_decay_reg <= cfg.data[16:0];
                REG_ADAPT_DECAY:     adapt_decay_reg     <= cfg.data[16:0];
                default: ;
            endcase
        end
    end

    // ---- pipeline control
    tag_t   tag_reg [NSTAGE];
    logic   out_valid_reg;
    logic   adv;
    logic   hazard;
    logic   accept;
    logic   clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // the whole pipeline moves when the output register is free or drains
    assign adv = !out_valid_reg || out_ch.ready;

    // hold a neuron that is still on its way to write-back
    always_comb
    begin
        hazard = 1'b0;
        for (int j = 0; j < NSTAGE; j++)
        begin
            if (tag_reg[j].valid && tag_reg[j].idx == in_ch.neuron_index)
                hazard = 1'b1;
        end
    end

    assign in_ch.ready = adv && !clr_busy_reg && !hazard;
    assign accept      = in_ch.valid && in_ch.ready;

    logic [31:0]   in_idx_wide;
    logic          in_range;
    logic [AW-1:0] rd_addr;
    assign in_idx_wide = 32'(in_ch.neuron_index);
    assign in_range    = in_idx_wide < 32'(NEURON_COUNT);
    assign rd_addr     = in_idx_wide[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NSTAGE; j++)
                tag_reg[j] <= '0;
        end
        else if (adv)
        begin
            tag_reg[0] <= '{valid: accept, idx: in_ch.neuron_index, inr: in_range};
            for (int j = 1; j < NSTAGE; j++)
                tag_reg[j] <= tag_reg[j-1];
        end
    end

    // ---- state memory, cleared by a sweep after reset
    row_t          mem [NEURON_COUNT];
    row_t          rd_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    row_t          wr_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (32'(clr_addr_reg) == 32'(NEURON_COUNT - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '{vm: RESET_POTENTIAL, vt: THRESHOLD_PEAK, x: '0};
        else if (wr_en)
            mem[wr_addr] <= wr_row;
        if (accept)
            rd_reg <= mem[rd_addr];
    end

    // ---- stage A: current rides with the memory read
    logic signed [31:0] a_cur_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            a_cur_reg <= in_ch.input_current;
    end

    // ---- stage B: differences
    logic signed [32:0] b_dvt_reg, b_del_reg, b_dcur_reg, b_dth_reg, b_dvel_reg;
    logic signed [31:0] b_vm_reg, b_vt_reg, b_x_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_dvt_reg  <= 33'(rd_reg.vm) - 33'(rd_reg.vt);
            b_del_reg  <= 33'(rest_potential_reg) - 33'(rd_reg.vm);
            b_dcur_reg <= 33'(a_cur_reg) - 33'(rd_reg.x);
            b_dth_reg  <= 33'(threshold_rest_reg) - 33'(rd_reg.vt);
            b_dvel_reg <= 33'(rd_reg.vm) - 33'(rest_potential_reg);
            b_vm_reg   <= rd_reg.vm;
            b_vt_reg   <= rd_reg.vt;
            b_x_reg    <= rd_reg.x;
        end
    end

    // ---- stage C: gain products, floored to Q16.16
    logic signed [63:0] p_arg, p_leak, p_in, p_th, p_ad;
    always_comb
    begin
        p_arg  = 64'(b_dvt_reg)  * 64'($signed({1'b0, inv_slope_reg}));
        p_leak = 64'(b_del_reg)  * 64'($signed({1'b0, leak_gain_reg}));
        p_in   = 64'(b_dcur_reg) * 64'($signed({1'b0, input_gain_reg}));
        p_th   = 64'(b_dth_reg)  * 64'($signed({1'b0, threshold_decay_reg}));
        p_ad   = 64'(b_dvel_reg) * 64'(ADAPT_COUPLING);
    end

    logic signed [47:0] c_arg_reg, c_pl_reg, c_pin_reg, c_pth_reg, c_pad_reg;
    logic signed [31:0] c_vm_reg, c_vt_reg, c_x_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_arg_reg <= p_arg[63:16];
            c_pl_reg  <= p_leak[63:16];
            c_pin_reg <= p_in[63:16];
            c_pth_reg <= p_th[63:16];
            c_pad_reg <= p_ad[63:16];
            c_vm_reg  <= b_vm_reg;
            c_vt_reg  <= b_vt_reg;
            c_x_reg   <= b_x_reg;
        end
    end

    // ---- stage D: clamp exponent argument, adaptation drive, partial sums
    logic signed [21:0] d_a_reg;
    logic signed [31:0] d_drive_reg, d_vtn_reg, d_x_reg;
    logic signed [49:0] d_vmsum_reg;
    logic signed [47:0] a_clamped;
    logic signed [63:0] vmsum_full;
    always_comb
    begin
        if (c_arg_reg < EXP_ARG_MIN)
            a_clamped = EXP_ARG_MIN;
        else if (c_arg_reg > EXP_ARG_MAX)
            a_clamped = EXP_ARG_MAX;
        else
            a_clamped = c_arg_reg;
        vmsum_full = 64'(c_vm_reg) + 64'(c_pl_reg) + 64'(c_pin_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_a_reg     <= a_clamped[21:0];
            d_drive_reg <= sat32(64'(c_pad_reg) - 64'(c_x_reg));
            d_vtn_reg   <= sat32(64'(c_vt_reg) + 64'(c_pth_reg));
            d_vmsum_reg <= vmsum_full[49:0];
            d_x_reg     <= c_x_reg;
        end
    end

    // ---- stage E: base-2 exponent, adaptation decay product
    logic signed [63:0] p_y, p_adec;
    always_comb
    begin
        p_y    = 64'(d_a_reg) * 64'(LOG2E_Q16);
        p_adec = 64'($signed({1'b0, adapt_decay_reg})) * 64'(d_drive_reg);
    end

    logic signed [23:0] e_y_reg;
    logic signed [33:0] e_padec_reg;
    logic signed [31:0] e_vtn_reg, e_x_reg;
    logic signed [49:0] e_vmsum_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_y_reg     <= p_y[39:16];
            e_padec_reg <= p_adec[49:16];
            e_vtn_reg   <= d_vtn_reg;
            e_vmsum_reg <= d_vmsum_reg;
            e_x_reg     <= d_x_reg;
        end
    end

    // ---- stage F: table interpolation of the fraction, new adaptation
    logic [3:0]  f_i;
    logic [11:0] f_r;
    logic [17:0] t_lo, t_hi;
    logic [24:0] interp;
    always_comb
    begin
        f_i    = e_y_reg[15:12];
        f_r    = e_y_reg[11:0];
        t_lo   = pow2_frac({1'b0, f_i});
        t_hi   = pow2_frac(5'({1'b0, f_i}) + 5'd1);
        interp = 25'(t_hi - t_lo) * 25'(f_r);
    end

    logic [17:0]        f_m_reg;
    logic signed [7:0]  f_k_reg;
    logic signed [31:0] f_nx_reg, f_vtn_reg;
    logic signed [49:0] f_vmsum_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_m_reg     <= t_lo + 18'(interp[24:12]);
            f_k_reg     <= e_y_reg[23:16];
            f_nx_reg    <= sat32(64'(e_x_reg) + 64'(e_padec_reg));
            f_vtn_reg   <= e_vtn_reg;
            f_vmsum_reg <= e_vmsum_reg;
        end
    end

    // ---- stage G: scale by the integer power of two, saturate
    logic signed [63:0] up_shift;
    logic [7:0]         neg_k;
    logic [30:0]        e_val;
    always_comb
    begin
        neg_k    = 8'(-f_k_reg);
        up_shift = $signed(64'(f_m_reg) << f_k_reg[4:0]);
        if (!f_k_reg[7])
            e_val = 31'(sat32(up_shift));
        else
            e_val = 31'(f_m_reg >> neg_k[4:0]);
    end

    logic [30:0]        g_e_reg;
    logic signed [31:0] g_nx_reg, g_vtn_reg;
    logic signed [49:0] g_vmsum_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_e_reg     <= e_val;
            g_nx_reg    <= f_nx_reg;
            g_vtn_reg   <= f_vtn_reg;
            g_vmsum_reg <= f_vmsum_reg;
        end
    end

    // ---- stage H: exponential drive product
    logic [63:0] p_exp;
    assign p_exp = 64'(exp_gain_reg) * 64'(g_e_reg);

    logic [45:0]        h_pe_reg;
    logic signed [31:0] h_nx_reg, h_vtn_reg;
    logic signed [49:0] h_vmsum_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_pe_reg    <= p_exp[61:16];
            h_nx_reg    <= g_nx_reg;
            h_vtn_reg   <= g_vtn_reg;
            h_vmsum_reg <= g_vmsum_reg;
        end
    end

    // ---- final stage: sum, fire decision, write-back, count
    logic signed [31:0] nvm_raw;
    logic               fire;
    logic [31:0]        spike_count_reg;
    logic [31:0]        count_next;
    tag_t               h_tag;

    assign h_tag = tag_reg[NSTAGE-1];

    always_comb
    begin
        nvm_raw = sat32(64'(h_vmsum_reg) + 64'($signed({1'b0, h_pe_reg})));
        fire    = h_tag.inr && (nvm_raw > h_vtn_reg);
        if (fire)
            wr_row = '{vm: RESET_POTENTIAL, vt: THRESHOLD_PEAK,
                       x: sat32(64'(h_nx_reg) + 64'(ADAPT_INCREMENT))};
        else
            wr_row = '{vm: nvm_raw, vt: h_vtn_reg, x: h_nx_reg};
        wr_en   = adv && h_tag.valid && h_tag.inr;
        wr_addr = 32'(h_tag.idx) < 32'(NEURON_COUNT) ? AW'(32'(h_tag.idx)) : '0;
        count_next = spike_count_reg;
        if (fire && spike_count_reg != 32'hFFFF_FFFF)
            count_next = spike_count_reg + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spike_count_reg <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= h_tag.valid;
            if (h_tag.valid)
                spike_count_reg <= count_next;
        end
    end

    logic [INDEX_W-1:0] out_id_reg;
    logic               out_spiked_reg;
    logic signed [31:0] out_vm_reg;
    logic [31:0]        out_total_reg;
    always_ff @(posedge clk)
    begin
        if (adv && h_tag.valid)
        begin
            out_id_reg     <= h_tag.idx;
            out_spiked_reg <= fire;
            out_vm_reg     <= h_tag.inr ? wr_row.vm : '0;
            out_total_reg  <= count_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.neuron_id    = out_id_reg;
    assign out_ch.spiked       = out_spiked_reg;
    assign out_ch.membrane_now = out_vm_reg;
    assign out_ch.total_spikes = out_total_reg;

endmodule

FILE: src/adex_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adex_chk
// Port-level checks of the neuron update block, bound to the top level.
// ---------------------------------------------------------------------------
module adex_chk #(
    parameter int NEURON_COUNT = adex_pkg::NEURON_COUNT_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [adex_pkg::INDEX_W-1:0]    out_id,
    input logic                            out_spiked,
    input logic signed [31:0]              out_vm,
    input logic [31:0]                     out_total
);
    import adex_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_vm) && $stable(out_total))
        else $error("result changed under stall");

    // a spike always reports the reset potential
    a_spike_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_spiked |-> out_vm == RESET_POTENTIAL)
        else $error("spike without reset potential");

    // only neurons that exist can fire
    a_spike_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_spiked |-> 32'(out_id) < 32'(NEURON_COUNT))
        else $error("spike on out-of-range neuron");

    // the count never falls from one beat to the next
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid && out_ready) |-> out_total >= $past(out_total))
        else $error("spike count decreased");

endmodule

bind adex_neuron_update adex_chk #(.NEURON_COUNT(NEURON_COUNT)) u_adex_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_id     (out_ch.neuron_id),
    .out_spiked (out_ch.spiked),
    .out_vm     (out_ch.membrane_now),
    .out_total  (out_ch.total_spikes)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for adex_neuron_update. It drives neuron step beats,
// predicts each result in a behavioral copy of the neuron array, and compares
// every output beat field by field. Runs several register settings under
// sender and receiver idling, plus a long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;
    import adex_pkg::*;

    localparam int  NEURONS     = NEURON_COUNT_DEF;
    localparam int  PIPE_DRAIN  = 16;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_ITEMS  = 1650;
    localparam int  N_SETTINGS  = 5;
    localparam int  N_DIRECTED  = 14;
    localparam int  NO_CFG      = -1;

    // 2^(i/16) in Q16.16, used by the exponential lookup
    localparam longint POW2_STEP [17] = '{
        65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92681,
        96785, 101070, 105544, 110217, 115097, 120193, 125514, 131072
    };

    typedef struct {
        logic [INDEX_W-1:0] id;
        logic               spk;
        logic [31:0]        vm;
        logic [31:0]        tot;
    } step_beat_t;

    typedef struct {
        int                 cfg_set;   // setting applied before this row
        logic [INDEX_W-1:0] idx;
        logic [31:0]        cur;
        bit                 typed;     // expected values given in the row
        logic               spk;
        logic [31:0]        vm;
        logic [31:0]        tot;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    adex_in_if  in_ch ();
    adex_out_if out_ch ();
    adex_cfg_if cfg ();

    adex_neuron_update dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always #4 clk = ~clk;

    // Predictor state: registers as written, masked to width, and the array
    logic [31:0]        reg_shadow [8];
    logic signed [31:0] vm_model   [NEURONS];
    logic signed [31:0] vt_model   [NEURONS];
    logic signed [31:0] adapt_model[NEURONS];
    logic [31:0]        spike_total;

    step_beat_t pending_beats[$];
    int         fail_count = 0;
    int         src_idle = 0;
    int         snk_idle = 0;
    int         hold_left = 0;
    int         cycles = 0;

    logic [31:0] setting_tab [N_SETTINGS][8];
    directed_row_t directed [N_DIRECTED];

    function automatic int reg_width(input cfg_reg_t r);
        case (r)
            REG_REST_POTENTIAL, REG_THRESHOLD_REST: return 32;
            REG_THRESHOLD_DECAY, REG_ADAPT_DECAY:   return 17;
            default:                                return 31;
        endcase
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Table exponential: power of two split into integer and fraction parts
    function automatic longint exp_lookup(input longint a);
        longint y, k, f, m;
        int     i, r;
        if (a < -64'sd1048576)
            a = -64'sd1048576;
        if (a > 64'sd655360)
            a = 64'sd655360;
        y = (a * 94548) >>> 16;
        k = y >>> 16;
        f = y - (k <<< 16);
        i = int'(f >> 12) & 15;
        r = int'(f) & 12'hFFF;
        m = POW2_STEP[i] + (((POW2_STEP[i+1] - POW2_STEP[i]) * r) >>> 12);
        if (k >= 0)
            return (k > 20) ? 64'sd2147483647 : clamp_s32(m <<< k);
        if (k < -40)
            return 0;
        return m >>> (-k);
    endfunction

    function automatic step_beat_t advance_neuron(input logic [INDEX_W-1:0] id,
                                                  input logic [31:0] cur_bits);
        step_beat_t res;
        longint leak, el, eg, isl, ig, vtr, td, ad, cur;
        longint vm, vt, x, e, nvm, nvt, nx, drive;
        leak = longint'(reg_shadow[REG_LEAK_GAIN]);
        el   = longint'($signed(reg_shadow[REG_REST_POTENTIAL]));
        eg   = longint'(reg_shadow[REG_EXP_GAIN]);
        isl  = longint'(reg_shadow[REG_INV_SLOPE]);
        ig   = longint'(reg_shadow[REG_INPUT_GAIN]);
        vtr  = longint'($signed(reg_shadow[REG_THRESHOLD_REST]));
        td   = longint'(reg_shadow[REG_THRESHOLD_DECAY]);
        ad   = longint'(reg_shadow[REG_ADAPT_DECAY]);
        cur  = longint'($signed(cur_bits));
        vm   = vm_model[id];
        vt   = vt_model[id];
        x    = adapt_model[id];

        e     = exp_lookup(((vm - vt) * isl) >>> 16);
        nvm   = clamp_s32(vm + ((leak * (el - vm)) >>> 16) + ((eg * e) >>> 16)
                          + ((ig * (cur - x)) >>> 16));
        nvt   = clamp_s32(vt + ((td * (vtr - vt)) >>> 16));
        drive = clamp_s32(((longint'(ADAPT_COUPLING) * (vm - el)) >>> 16) - x);
        nx    = clamp_s32(x + ((ad * drive) >>> 16));

        res.spk = 1'b0;
        if (nvm > nvt)
        begin
            res.spk = 1'b1;
            nvm = RESET_POTENTIAL;
            nvt = THRESHOLD_PEAK;
            nx  = clamp_s32(nx + longint'(ADAPT_INCREMENT));
            if (spike_total != 32'hFFFFFFFF)
                spike_total = spike_total + 1;
        end
        vm_model[id]    = nvm[31:0];
        vt_model[id]    = nvt[31:0];
        adapt_model[id] = nx[31:0];
        res.id  = id;
        res.vm  = nvm[31:0];
        res.tot = spike_total;
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input cfg_reg_t r, input logic [31:0] value);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = r;
        cfg.data  = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (reg_width(r) == 32)
            reg_shadow[r] = value;
        else
            reg_shadow[r] = value & ((32'd1 << reg_width(r)) - 1);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Hold until every expected beat has come back, then let the pipe settle
    task automatic drain;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic apply_setting(input int s);
        // drop the last step beat before waiting, so it is not taken twice
        @(negedge clk);
        in_ch.valid = 1'b0;
        drain();
        for (int r = 0; r < 8; r++)
            write_reg(cfg_reg_t'(r), setting_tab[s][r]);
    endtask

    // Offer one step beat; queue its expectation when accepted
    task automatic send_step(input logic [INDEX_W-1:0] idx, input logic [31:0] cur,
                             input bit typed, input step_beat_t typed_beat);
        step_beat_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.neuron_index  = idx;
        in_ch.input_current = cur;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = advance_neuron(idx, cur);
        pending_beats.push_back(typed ? typed_beat : predicted);
    endtask

    function automatic logic [31:0] pick_current();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom_range(32'd600 << 16) - (32'd100 << 16);
        if (sel < 75)
            return $urandom;
        return $urandom_range(32'h1FFFF) - 32'h10000;
    endfunction

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(99) >= snk_idle);
    end

    // Compare each output beat against the oldest expectation
    always @(posedge clk)
    begin
        step_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_beats.size() == 0)
            begin
                report("unexpected beat, neuron_id", 32'(out_ch.neuron_id), '0);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_ch.neuron_id !== want.id)
                    report("neuron_id", 32'(out_ch.neuron_id), 32'(want.id));
                if (out_ch.spiked !== want.spk)
                    report("spiked", 32'(out_ch.spiked), 32'(want.spk));
                if (out_ch.membrane_now !== want.vm)
                    report("membrane_now", out_ch.membrane_now, want.vm);
                if (out_ch.total_spikes !== want.tot)
                    report("total_spikes", out_ch.total_spikes, want.tot);
            end
        end
    end

    // Watchdog: the clearing pass and all stalls fit well inside the limit
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        step_beat_t typed_beat;
        logic [INDEX_W-1:0] last_idx;
        int sel, base;

        in_ch.valid = 1'b0;
        in_ch.neuron_index = '0;
        in_ch.input_current = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_LEAK_GAIN;
        cfg.data  = '0;
        out_ch.ready = 1'b0;

        // Predictor reset state
        for (int r = 0; r < 8; r++)
            reg_shadow[r] = '0;
        reg_shadow[REG_INV_SLOPE] = 32'd65536;
        for (int n = 0; n < NEURONS; n++)
        begin
            vm_model[n]    = RESET_POTENTIAL;
            vt_model[n]    = THRESHOLD_PEAK;
            adapt_model[n] = '0;
        end
        spike_total = '0;

        // Settings: a biological one, both extremes, a fast one, random
        setting_tab[0] = '{32'd655, -32'sd4626842, 32'd1310, 32'd32768, 32'd6554,
                           -32'sd3276800, 32'd3277, 32'd655};
        setting_tab[1] = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'd65536};
        setting_tab[2] = '{32'd0, 32'h80000000, 32'd0, 32'd0, 32'd0,
                           32'h80000000, 32'd0, 32'd0};
        setting_tab[3] = '{32'd6554, -32'sd4600000, 32'd13107, 32'd65536, 32'd65536,
                           -32'sd2000000, 32'd65536, 32'd65536};
        for (int r = 0; r < 8; r++)
            setting_tab[4][r] = $urandom;

        // Under reset registers nothing moves: the membrane stays at reset
        directed[0]  = '{NO_CFG, 10'd0,    32'h00000000, 1, 1'b0, RESET_POTENTIAL, 0};
        directed[1]  = '{NO_CFG, 10'd1023, 32'h7FFFFFFF, 1, 1'b0, RESET_POTENTIAL, 0};
        directed[2]  = '{NO_CFG, 10'd512,  32'h80000000, 1, 1'b0, RESET_POTENTIAL, 0};
        directed[3]  = '{NO_CFG, 10'd0,    32'hFFFFFFFF, 1, 1'b0, RESET_POTENTIAL, 0};
        directed[4]  = '{NO_CFG, 10'd0,    32'h00010000, 1, 1'b0, RESET_POTENTIAL, 0};
        // Biological setting: drive neuron 0 hard until it fires
        directed[5]  = '{0, 10'd0,    32'd400 << 16, 0, 1'b0, '0, '0};
        directed[6]  = '{NO_CFG, 10'd0,    32'd400 << 16, 0, 1'b0, '0, '0};
        directed[7]  = '{NO_CFG, 10'd0,    32'd400 << 16, 0, 1'b0, '0, '0};
        directed[8]  = '{NO_CFG, 10'd1023, 32'h7FFFFFFF, 0, 1'b0, '0, '0};
        directed[9]  = '{NO_CFG, 10'd1023, 32'h80000000, 0, 1'b0, '0, '0};
        // Saturating extremes on both ends
        directed[10] = '{1, 10'd1023, 32'h7FFFFFFF, 0, 1'b0, '0, '0};
        directed[11] = '{NO_CFG, 10'd1023, 32'h80000000, 0, 1'b0, '0, '0};
        directed[12] = '{2, 10'd0,    32'h7FFFFFFF, 0, 1'b0, '0, '0};
        directed[13] = '{NO_CFG, 10'd1023, 32'h80000000, 0, 1'b0, '0, '0};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, no idling
        for (int d = 0; d < N_DIRECTED; d++)
        begin
            if (directed[d].cfg_set != NO_CFG)
                apply_setting(directed[d].cfg_set);
            typed_beat = '{directed[d].idx, directed[d].spk, directed[d].vm,
                           directed[d].tot};
            send_step(directed[d].idx, directed[d].cur, directed[d].typed, typed_beat);
        end

        // Random part: walk the settings, idling mode by overall progress
        last_idx = '0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % (RAND_ITEMS / N_SETTINGS) == 0 && n / (RAND_ITEMS / N_SETTINGS) < N_SETTINGS)
            begin
                apply_setting((n / (RAND_ITEMS / N_SETTINGS) + 3) % N_SETTINGS);
                // Long hold-off so the pipe fills and stalls its input
                if (n == 0)
                    hold_left = 300;
            end
            if (n < RAND_ITEMS / 3)
            begin
                src_idle = 13;
                snk_idle = 56;
            end
            else if (n < 2 * RAND_ITEMS / 3)
            begin
                src_idle = 56;
                snk_idle = 13;
            end
            else
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            // Mostly a small pool of neurons so they charge up and fire
            sel = $urandom_range(99);
            base = $urandom_range(15);
            if (sel < 60)
                last_idx = base[INDEX_W-1:0];
            else if (sel < 70)
                last_idx = last_idx;
            else
                last_idx = INDEX_W'($urandom_range(NEURONS - 1));
            send_step(last_idx, pick_current(), 0, typed_beat);
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
